>>> sv/plt_pkg.sv
// Shared constants, codes and types of the peer liveness table.
package plt_pkg;

    localparam int PEER_SLOTS_DEF = 32;

    localparam int ID_W     = 64;
    localparam int TICK_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_HEARD = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_ID = 1'd1;

    localparam logic [ID_W-1:0] LOCAL_ID_RESET  = 64'h1234_5678_9ABC_DEF0;
    localparam logic [ID_W-1:0] SHARED_ID_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ID_W-1:0] local_id;
        logic [ID_W-1:0] shared_id;
    } t_ids;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [TICK_W-1:0]   elapsed;
    } t_result;

endpackage

>>> sv/peer_liveness_table_unit.sv
// Top level of the peer liveness table: stream ports, id registers and result register.
//
// Each transaction is handled one at a time. A tick, an ignored own or shared id, or an
// unused function code goes from the decode state straight to the done state. A heard-from or
// query transaction scans every slot through one read port of the slot memory and one
// 64-bit comparator, one slot per cycle, then passes through a write state; a query that
// hits also passes through a state for the elapsed-tick subtraction.
// The input is ready again once the previous result has moved into the output register,
// so one result may wait there while the next transaction is being worked on. Slot
// contents need no clearing after reset: per-slot valid bits are cleared at once.
module peer_liveness_table_unit
    import plt_pkg::*;
#(
    parameter int PEER_SLOTS = PEER_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ID_W-1:0]      s_axis_tdata,   // [63:0] peer_id
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,   // [2:0] status, [3] found,
                                                 // [67:4] elapsed_ticks, [71:68] zero
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ID_W-1:0]      i_cfg_data
);

    t_ids    r_ids;
    logic    r_out_valid;
    t_result r_out;
    logic    scan_idle;
    logic    scan_done;
    logic    take;
    t_result scan_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids.local_id  <= LOCAL_ID_RESET;
            r_ids.shared_id <= SHARED_ID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCAL_ID:  r_ids.local_id  <= i_cfg_data;
                CFG_SHARED_ID: r_ids.shared_id <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    plt_scan #(
        .PEER_SLOTS(PEER_SLOTS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_axis_tvalid),
        .i_func   (s_axis_tuser),
        .i_id     (s_axis_tdata),
        .i_ids    (r_ids),
        .o_idle   (scan_idle),
        .o_done   (scan_done),
        .o_result (scan_res),
        .i_take   (take)
    );

    assign s_axis_tready = scan_idle;

    // move a finished result out when the output register is free or draining
    assign take = scan_done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= scan_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.elapsed, r_out.found, r_out.status};

endmodule

>>> sv/plt_slot_mem.sv
// Slot storage: peer id and last-seen tick per slot, one write and one registered read port.
module plt_slot_mem
    import plt_pkg::*;
#(
    parameter int PEER_SLOTS = PEER_SLOTS_DEF,
    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [ID_W-1:0]   i_wpeer,
    input  logic [TICK_W-1:0] i_wtick,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [ID_W-1:0]   o_rpeer,
    output logic [TICK_W-1:0] o_rtick
);

    logic [ID_W-1:0]   r_peer [PEER_SLOTS];
    logic [TICK_W-1:0] r_tick [PEER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_peer[i_waddr] <= i_wpeer;
            r_tick[i_waddr] <= i_wtick;
        end
        o_rpeer <= r_peer[i_raddr];
        o_rtick <= r_tick[i_raddr];
    end

endmodule

>>> sv/plt_scan.sv
// Sequencer: tick counter, slot valid bits and a one-compare-per-cycle slot scan.
module plt_scan
    import plt_pkg::*;
#(
    parameter int PEER_SLOTS = PEER_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [ID_W-1:0]   i_id,
    input  t_ids              i_ids,
    output logic              o_idle,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_take
);

    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CNT_W = $clog2(PEER_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(PEER_SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_SUB    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [FUNC_W-1:0]     r_func;
    logic [ID_W-1:0]       r_id;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [PEER_SLOTS-1:0] r_used, n_used;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_cmp_v, n_cmp_v;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [TICK_W-1:0]     r_hit_tick, n_hit_tick;
    logic                  r_free_v, n_free_v;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    t_result               r_res, n_res;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [ID_W-1:0]       rd_peer;
    logic [TICK_W-1:0]     rd_tick;
    logic                  cmp_used;

    plt_slot_mem #(
        .PEER_SLOTS(PEER_SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wpeer (r_id),
        .i_wtick (r_tick),
        .i_raddr (mem_raddr),
        .o_rpeer (rd_peer),
        .o_rtick (rd_tick)
    );

    assign mem_raddr = r_cnt[IDX_W-1:0];
    assign cmp_used  = r_used[r_cmp_idx];

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_cmp_v    = r_cmp_v;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_tick = r_hit_tick;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_hit_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res.status  = ST_DONE;
                n_res.found   = 1'b0;
                n_res.elapsed = '0;
                n_cnt         = '0;
                n_cmp_v       = 1'b0;
                n_hit         = 1'b0;
                n_free_v      = 1'b0;
                n_state       = S_DONE;
                case (r_func)
                    FN_TICK: begin
                        n_tick = r_tick + TICK_W'(1);
                    end
                    FN_HEARD: begin
                        if (r_id == i_ids.local_id || r_id == i_ids.shared_id) begin
                            n_res.status = ST_IGNORED;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_QUERY: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // compare the slot read last cycle, issue the next read
                if (r_cmp_v) begin
                    if (cmp_used && rd_peer == r_id && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_cmp_idx;
                        n_hit_tick = rd_tick;
                    end
                    if (!cmp_used && !r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                if (r_cnt != CNT_END) begin
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = mem_raddr;
                    n_cnt     = r_cnt + CNT_W'(1);
                end else begin
                    n_cmp_v = 1'b0;
                    if (!r_cmp_v) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
                if (r_func == FN_QUERY) begin
                    if (r_hit) begin
                        n_res.found = 1'b1;
                        n_state     = S_SUB;
                    end else begin
                        n_res.elapsed = '1;
                    end
                end else if (r_hit) begin
                    mem_we       = 1'b1;
                    n_res.status = ST_REFRESHED;
                end else if (r_free_v) begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_free_idx;
                    n_used[r_free_idx] = 1'b1;
                    n_res.status       = ST_INSERTED;
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            S_SUB: begin
                n_res.elapsed = r_tick - r_hit_tick;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= '0;
            r_used  <= '0;
            r_cnt   <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
            r_cmp_v <= n_cmp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_func <= i_func;
            r_id   <= i_id;
        end
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_tick <= n_hit_tick;
        r_free_v   <= n_free_v;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

endmodule
